/* design/rgb_to_hsl_convert_assert.svh */
// Assertion macros shared by the checker files of the color converter.
// No dependencies; include by bare file name inside a module body.
`ifndef RGB_TO_HSL_CONVERT_ASSERT_SVH
`define RGB_TO_HSL_CONVERT_ASSERT_SVH

// Same-cycle implication, disabled while rst is high
`define RHC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhc assertion failed");

// Next-cycle implication, disabled while rst is high
`define RHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rhc assertion failed");

`endif

/* design/rhc_pkg.sv */
// Shared constants and datapath types of the RGB to HSL converter.
// No dependencies; imported by the converter, its divider and its checker.
package rhc_pkg;

   // fraction bits of every result; results are Q1.FRAC_BITS
   localparam int FRAC_BITS = 16;
   localparam int QW        = FRAC_BITS + 1;   // result field width
   localparam int DW        = 11;              // divisor width, holds 6*255
   localparam int RW        = DW + 1;          // partial remainder width
   localparam int LANES     = 2;

   // lane slots in the divider word
   localparam int LANE_HUE = 0;
   localparam int LANE_SAT = 1;

   localparam logic [QW-1:0] ONE_FX  = QW'(1) << FRAC_BITS;

   // lightness s * 2^F / 510 = s * LIG_Q + s * LIG_R / 255,
   // where 2^(F-1) = 255 * LIG_Q + LIG_R and LIG_R is a power of two
   localparam int            LIG_SH = (FRAC_BITS - 1) % 8;
   localparam logic [7:0]    LIG_R  = 8'(1 << LIG_SH);
   localparam logic [QW-1:0] LIG_Q  = QW'(((1 << (FRAC_BITS - 1)) - (1 << LIG_SH)) / 255);

   // one division in flight: remainder, divisor, quotient so far
   typedef struct packed {
      logic [RW-1:0] rem;
      logic [DW-1:0] dvs;
      logic [QW-1:0] quo;
   } div_lane_type;

   // word moving through the divider pipeline
   typedef struct packed {
      logic                           grey;
      logic [QW-1:0]                  lig;
      div_lane_type [LANES-1:0]       lane;
   } div_word_type;

endpackage

/* design/rhc_div_pipe.sv */
// Pipelined restoring divider: two lanes, one quotient bit per stage,
// lightness carried alongside. Depends on rhc_pkg for widths and the word type.
module rhc_div_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rhc_pkg::div_word_type in_word,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rhc_pkg::div_word_type out_word
);
   import rhc_pkg::*;

   // one restoring step: compare, subtract, shift in the quotient bit
   function automatic div_lane_type div_step(input div_lane_type x);
      div_lane_type  y;
      logic          q_bit;
      logic [RW-1:0] diff;
      q_bit = (x.rem >= {1'b0, x.dvs});
      diff  = q_bit ? (x.rem - {1'b0, x.dvs}) : x.rem;
      y.rem = {diff[RW-2:0], 1'b0};
      y.dvs = x.dvs;
      y.quo = {x.quo[QW-2:0], q_bit};
      return y;
   endfunction

   logic         v_ff  [QW];
   div_word_type w_ff  [QW];
   div_word_type w_in  [QW];
   logic         stage_ready [QW+1];

   // ready ripples back; an empty stage can always load
   always_comb begin
      stage_ready[QW] = out_ready;
      for (int k = QW - 1; k >= 0; k--) begin
         stage_ready[k] = !v_ff[k] || stage_ready[k+1];
      end
   end

   // next word of every stage
   always_comb begin
      w_in[0] = in_word;
      for (int k = 1; k < QW; k++) w_in[k] = w_ff[k-1];
      for (int k = 0; k < QW; k++) begin
         for (int l = 0; l < LANES; l++) begin
            w_in[k].lane[l] = div_step(w_in[k].lane[l]);
         end
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QW; k++) v_ff[k] <= 1'b0;
      end else begin
         if (stage_ready[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < QW; k++) begin
            if (stage_ready[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++) begin
         if (stage_ready[k]) w_ff[k] <= w_in[k];
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = v_ff[QW-1];
   assign out_word  = w_ff[QW-1];

endmodule

/* design/rgb_to_hsl_convert.sv */
// RGB to HSL converter: takes one 8-bit RGB pixel per word and returns hue,
// saturation and lightness as Q1.16 fractions, truncated, 65536 meaning 1.0.
// It accepts one pixel every clock and delivers one result every clock when
// the result side keeps up; the pipeline holds, in order:
// one stage for max/min, one for sector numerators, divisors and lightness
// (a constant reciprocal product), 17 stages of the two-lane restoring
// divider for hue and saturation (one quotient bit per stage), and the
// output register. Stalls are absorbed stage by stage, so empty stages keep
// taking pixels while a finished result waits. A grey pixel yields
// saturation 0 and hue 1.0; pure red yields hue 1.0.
// Depends on rhc_pkg and rhc_div_pipe.
module rgb_to_hsl_convert (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_red,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [rhc_pkg::QW-1:0] rsp_hue,
   output logic [rhc_pkg::QW-1:0] rsp_saturation,
   output logic [rhc_pkg::QW-1:0] rsp_lightness
);
   import rhc_pkg::*;

   // stage A: pixel with max, min and sector flags
   logic       a_v_ff;
   logic [7:0] a_r_ff, a_g_ff, a_b_ff, a_mx_ff, a_mn_ff;
   logic       a_bmax_ff, a_gmax_ff, a_ggtb_ff;
   logic [7:0] mx_in, mn_in;
   logic       a_ready;

   // stage B: divider input word
   logic         b_v_ff;
   div_word_type b_ff, b_in;
   logic         b_ready;

   // divider and output
   logic         div_in_ready, div_out_valid, div_out_ready;
   div_word_type div_out;
   logic         rsp_valid_ff;
   logic [QW-1:0] hue_ff, sat_ff, lig_ff;

   // ready chain back from the output register
   assign div_out_ready = !rsp_valid_ff || rsp_ready;
   assign b_ready       = !b_v_ff || div_in_ready;
   assign a_ready       = !a_v_ff || b_ready;
   assign req_ready     = a_ready;

   // max and min of the three channels
   always_comb begin
      mx_in = req_red;
      mn_in = req_red;
      if (req_green > mx_in) mx_in = req_green;
      if (req_blue  > mx_in) mx_in = req_blue;
      if (req_green < mn_in) mn_in = req_green;
      if (req_blue  < mn_in) mn_in = req_blue;
   end

   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (a_ready) a_v_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_r_ff    <= req_red;
         a_g_ff    <= req_green;
         a_b_ff    <= req_blue;
         a_mx_ff   <= mx_in;
         a_mn_ff   <= mn_in;
         a_bmax_ff <= (req_blue == mx_in);
         a_gmax_ff <= (req_green == mx_in);
         a_ggtb_ff <= (req_green > req_blue);
      end
   end

   // sector numerator, the two divisors and lightness
   always_comb begin
      logic [7:0]  d;
      logic [8:0]  s;
      logic [11:0] d12, r12, g12, b12, num12, d6;
      logic [8:0]  sat_den;
      logic [15:0] lig_y;
      logic [16:0] lig_t;
      d   = a_mx_ff - a_mn_ff;
      s   = {1'b0, a_mx_ff} + {1'b0, a_mn_ff};
      d12 = {4'b0, d};
      r12 = {4'b0, a_r_ff};
      g12 = {4'b0, a_g_ff};
      b12 = {4'b0, a_b_ff};
      d6  = (d12 << 2) + (d12 << 1);
      if (a_bmax_ff)      num12 = (d12 << 2) + r12 - g12;
      else if (a_gmax_ff) num12 = (d12 << 1) + b12 - r12;
      else if (a_ggtb_ff) num12 = g12 - b12;
      else                num12 = d6 + g12 - b12;
      sat_den = (s <= 9'd255) ? s : (9'd510 - s);

      // y / 255 as (y + y/256 + 1) / 256, exact for y below 65535
      lig_y = 16'(s) * 16'(LIG_R);
      lig_t = 17'(lig_y) + 17'(lig_y >> 8) + 17'd1;

      b_in.grey               = (d == 8'd0);
      b_in.lig                = QW'(s) * LIG_Q + QW'(lig_t[16:8]);
      b_in.lane[LANE_HUE].rem = RW'(num12[DW-1:0]);
      b_in.lane[LANE_HUE].dvs = d6[DW-1:0];
      b_in.lane[LANE_HUE].quo = '0;
      b_in.lane[LANE_SAT].rem = RW'(d);
      b_in.lane[LANE_SAT].dvs = DW'(sat_den);
      b_in.lane[LANE_SAT].quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (b_ready) b_v_ff <= a_v_ff;
   end

   always_ff @(posedge clock) begin
      if (b_ready) b_ff <= b_in;
   end

   rhc_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_v_ff),
      .in_ready  (div_in_ready),
      .in_word   (b_ff),
      .out_valid (div_out_valid),
      .out_ready (div_out_ready),
      .out_word  (div_out)
   );

   // output register; grey pixels override hue and saturation
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (div_out_ready) rsp_valid_ff <= div_out_valid;
   end

   always_ff @(posedge clock) begin
      if (div_out_ready) begin
         hue_ff <= div_out.grey ? ONE_FX : div_out.lane[LANE_HUE].quo;
         sat_ff <= div_out.grey ? '0     : div_out.lane[LANE_SAT].quo;
         lig_ff <= div_out.lig;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_lightness  = lig_ff;

endmodule

/* design/rhc_checker.sv */
// Port-level checker for the RGB to HSL converter, bound to its top level.
// Depends on rhc_pkg and the macros in rgb_to_hsl_convert_assert.svh.
module rhc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [7:0]             req_red,
   input logic [7:0]             req_green,
   input logic [7:0]             req_blue,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [rhc_pkg::QW-1:0] rsp_hue,
   input logic [rhc_pkg::QW-1:0] rsp_saturation,
   input logic [rhc_pkg::QW-1:0] rsp_lightness
);
   import rhc_pkg::*;
   `include "rgb_to_hsl_convert_assert.svh"

   logic            req_stall;
   logic            rsp_stall;
   logic [23:0]     req_pixel;
   logic [3*QW-1:0] rsp_fields;
   logic            rsp_in_range;

   assign req_stall    = req_valid && !req_ready;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign req_pixel    = {req_red, req_green, req_blue};
   assign rsp_fields   = {rsp_hue, rsp_saturation, rsp_lightness};
   assign rsp_in_range = (rsp_hue <= ONE_FX) && (rsp_saturation <= ONE_FX)
                         && (rsp_lightness <= ONE_FX);

   // a stalled pixel word holds
   `RHC_ASSERT_NEXT(a_req_hold, clock, reset, req_stall, req_valid && $stable(req_pixel))

   // a stalled result word holds
   `RHC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_fields))

   // every field stays within 1.0
   `RHC_ASSERT_IMPL(a_rsp_range, clock, reset, rsp_valid, rsp_in_range)

   // zero saturation only for grey, which carries hue 1.0
   `RHC_ASSERT_IMPL(a_grey_hue, clock, reset, rsp_valid && rsp_saturation == '0, rsp_hue == ONE_FX)

   // reset empties the pipeline
   `RHC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind rgb_to_hsl_convert rhc_checker u_rhc_checker (.*);

/* tb/tb.sv */
// Testbench of rgb_to_hsl_convert: directed pixel table, then random pixels under
// changing sender and receiver idling, each result checked field by field.
// Depends on rhc_pkg (result width and fraction bits) and the converter RTL.
module tb;
   import rhc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;   // far above the slowest legal run
   localparam int LATENCY     = FRAC_BITS + 4;
   localparam int N_RANDOM    = 800;
   localparam int N_ROWS      = 21;
   localparam int HOLD_CYCLES = 300;      // long receiver stall in the last phase

   // one converted pixel
   typedef struct packed {
      logic [QW-1:0] hue;
      logic [QW-1:0] saturation;
      logic [QW-1:0] lightness;
   } hsl_type;

   // directed row: pixel, plus a typed-in result where known outright
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       typed;
      hsl_type    hsl;
   } pixel_row_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [7:0]    req_red;
   logic [7:0]    req_green;
   logic [7:0]    req_blue;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [QW-1:0] rsp_hue;
   logic [QW-1:0] rsp_saturation;
   logic [QW-1:0] rsp_lightness;

   hsl_type       hsl_expected[$];
   pixel_row_type pixel_rows[N_ROWS];
   int            send_idle_pct;
   int            recv_idle_pct;
   int            hold_left;
   int            err_count;
   int            pixels_sent;
   int            grey_sent;
   int            results_checked;
   int            cycle_count;

   rgb_to_hsl_convert i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_lightness  (rsp_lightness)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     hsl_expected.size());
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // HSL of one pixel, exact integer division then truncation
   function automatic hsl_type hsl_of_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      longint unsigned rr, gg, bb, mx, mn, d, s, num, hue, sat, lig;
      hsl_type res;
      rr = r;
      gg = g;
      bb = b;
      mx = rr;
      mn = rr;
      if (gg > mx) mx = gg;
      if (bb > mx) mx = bb;
      if (gg < mn) mn = gg;
      if (bb < mn) mn = bb;
      d = mx - mn;
      s = mx + mn;
      lig = (s << FRAC_BITS) / 510;
      if (d == 0) begin
         // grey: hue reads as a full turn
         hue = 64'd1 << FRAC_BITS;
         sat = 0;
      end else begin
         if (s <= 255) sat = (d << FRAC_BITS) / s;
         else sat = (d << FRAC_BITS) / (510 - s);
         // blue max wins over green max, green over red
         if (bb == mx) num = 4 * d + rr - gg;
         else if (gg == mx) num = 2 * d + bb - rr;
         else if (gg > bb) num = gg - bb;
         else num = 6 * d + gg - bb;
         hue = (num << FRAC_BITS) / (6 * d);
      end
      res.hue        = QW'(hue);
      res.saturation = QW'(sat);
      res.lightness  = QW'(lig);
      return res;
   endfunction

   // offer one pixel word, idling first at the current sender rate
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic typed, input hsl_type typed_hsl);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (!(req_valid && req_ready));
      hsl_expected.push_back(typed ? typed_hsl : hsl_of_pixel(r, g, b));
      pixels_sent++;
      if (r == g && g == b) grey_sent++;
   endtask

   // receiver: random idling, or a counted hold-off when one is pending
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      hsl_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hsl_expected.size() == 0) begin
            $display("%0t: unexpected result hue %0d sat %0d light %0d", $time,
                     rsp_hue, rsp_saturation, rsp_lightness);
            err_count++;
         end else begin
            want = hsl_expected.pop_front();
            results_checked++;
            if (rsp_hue !== want.hue) begin
               $display("%0t: hue expected %0d got %0d", $time, want.hue, rsp_hue);
               err_count++;
            end
            if (rsp_saturation !== want.saturation) begin
               $display("%0t: saturation expected %0d got %0d", $time,
                        want.saturation, rsp_saturation);
               err_count++;
            end
            if (rsp_lightness !== want.lightness) begin
               $display("%0t: lightness expected %0d got %0d", $time,
                        want.lightness, rsp_lightness);
               err_count++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [7:0] v[3];
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] t;
      int         lo;
      int         k;
      int         n;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_red         = '0;
      req_green       = '0;
      req_blue        = '0;
      rsp_ready       = 1'b0;
      hold_left       = 0;
      err_count       = 0;
      pixels_sent     = 0;
      grey_sent       = 0;
      results_checked = 0;
      send_idle_pct   = 29;
      recv_idle_pct   = 54;

      // red, green, blue, typed, {hue, saturation, lightness}
      pixel_rows = '{
         '{8'd0,   8'd0,   8'd0,   1'b1, '{17'd65536, 17'd0,     17'd0}},      // black
         '{8'd255, 8'd255, 8'd255, 1'b1, '{17'd65536, 17'd0,     17'd65536}},  // white
         '{8'd128, 8'd128, 8'd128, 1'b1, '{17'd65536, 17'd0,     17'd32896}},  // mid grey
         '{8'd255, 8'd0,   8'd0,   1'b1, '{17'd65536, 17'd65536, 17'd32768}},  // pure red
         '{8'd0,   8'd255, 8'd0,   1'b1, '{17'd21845, 17'd65536, 17'd32768}},  // pure green
         '{8'd0,   8'd0,   8'd255, 1'b1, '{17'd43690, 17'd65536, 17'd32768}},  // pure blue
         '{8'd255, 8'd255, 8'd0,   1'b1, '{17'd10922, 17'd65536, 17'd32768}},  // green beats red
         '{8'd0,   8'd255, 8'd255, 1'b1, '{17'd32768, 17'd65536, 17'd32768}},  // blue beats green
         '{8'd255, 8'd0,   8'd255, 1'b1, '{17'd54613, 17'd65536, 17'd32768}},  // blue beats red
         '{8'd255, 8'd0,   8'd1,   1'b0, '{17'd0,     17'd0,     17'd0}},
         '{8'd255, 8'd1,   8'd0,   1'b0, '{17'd0,     17'd0,     17'd0}},
         '{8'd1,   8'd0,   8'd0,   1'b0, '{17'd0,     17'd0,     17'd0}},
         '{8'd0,   8'd1,   8'd0,   1'b0, '{17'd0,     17'd0,     17'd0}},
         '{8'd0,   8'd0,   8'd1,   1'b0, '{17'd0,     17'd0,     17'd0}},
         '{8'd255, 8'd254, 8'd254, 1'b0, '{17'd0,     17'd0,     17'd0}},
         '{8'd128, 8'd127, 8'd127, 1'b0, '{17'd0,     17'd0,     17'd0}},
         '{8'd128, 8'd128, 8'd127, 1'b0, '{17'd0,     17'd0,     17'd0}},
         '{8'd129, 8'd128, 8'd128, 1'b0, '{17'd0,     17'd0,     17'd0}},
         '{8'd170, 8'd85,  8'd0,   1'b0, '{17'd0,     17'd0,     17'd0}},
         '{8'd85,  8'd170, 8'd255, 1'b0, '{17'd0,     17'd0,     17'd0}},
         '{8'd0,   8'd128, 8'd255, 1'b0, '{17'd0,     17'd0,     17'd0}}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < N_ROWS; i++) begin
         send_pixel(pixel_rows[i].red, pixel_rows[i].green, pixel_rows[i].blue,
                    pixel_rows[i].typed, pixel_rows[i].hsl);
      end

      // random pixels in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_left     = HOLD_CYCLES;   // back up the pipe and stall the input
            end
         endcase
         n = (phase == 2) ? N_RANDOM - 2 * (N_RANDOM / 3) : N_RANDOM / 3;
         for (int j = 0; j < n; j++) begin
            x = 8'($urandom_range(0, 255));
            y = 8'($urandom_range(0, 255));
            v[0] = 8'($urandom_range(0, 255));
            v[1] = 8'($urandom_range(0, 255));
            v[2] = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
               4: begin
                  // grey
                  v[0] = x;
                  v[1] = x;
                  v[2] = x;
               end
               5: begin
                  // two channels tie
                  v[0] = x;
                  v[1] = x;
                  v[2] = y;
               end
               6: begin
                  // channel extremes
                  for (int c = 0; c < 3; c++) begin
                     k = $urandom_range(0, 3);
                     v[c] = (k < 2) ? 8'(k) : 8'(252 + k);
                  end
               end
               7: begin
                  // max + min around 255, where the saturation formula switches
                  v[0] = 8'($urandom_range(128, 255));
                  lo = 255 - int'(v[0]) + int'($urandom_range(0, 2)) - 1;
                  if (lo < 0) lo = 0;
                  if (lo > int'(v[0])) lo = int'(v[0]);
                  v[1] = 8'(lo);
                  v[2] = 8'($urandom_range(lo, int'(v[0])));
               end
               8: begin
                  // spread of one
                  x = 8'($urandom_range(0, 254));
                  v[0] = x;
                  v[1] = x + 8'd1;
                  v[2] = x + 8'($urandom_range(0, 1));
               end
               default: ;
            endcase
            // any of the six channel orders
            k = $urandom_range(0, 2);
            x = v[k];
            y = v[(k + 1) % 3];
            t = v[(k + 2) % 3];
            if ($urandom_range(0, 1)) send_pixel(x, t, y, 1'b0, '0);
            else send_pixel(x, y, t, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // drain, then watch for stray results
      while (hsl_expected.size() != 0) @(posedge clock);
      repeat (3 * LATENCY) @(posedge clock);

      $display("tb: %0d pixels (%0d grey, %0d directed) converted, %0d results checked",
               pixels_sent, grey_sent, N_ROWS, results_checked);
      $display("tb: idling on either side, none, and a %0d-cycle receiver hold-off; %0d errors",
               HOLD_CYCLES, err_count);
      if (err_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
